/* hdl/assert_macros.svh */
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MTG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MTG_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MTG_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTG_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* hdl/mtg_pkg.sv */
`default_nettype none
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int WORD_W       = 32;

  localparam logic [31:0] MATRIX_A   = 32'h9908b0df;
  localparam logic [31:0] UPPER_MASK = 32'h80000000;
  localparam logic [31:0] LOWER_MASK = 32'h7fffffff;
  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc60000;
  localparam logic [31:0] DEFAULT_SEED_RST = 32'd5489;

  // action codes of an input word
  localparam logic [1:0] ACT_SEED   = 2'd0;
  localparam logic [1:0] ACT_DRAW   = 2'd1;
  localparam logic [1:0] ACT_DRAW64 = 2'd2;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_MUL,
    ALU_TWIST,
    ALU_TEMPER
  } alu_op_t;

  typedef struct packed {
    logic        en;
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_WR,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_DRAW_CHK,
    ST_TW_RD0,
    ST_TW_LD,
    ST_TW_RDN,
    ST_TW_RDS,
    ST_TW_CALC,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_TEMP,
    ST_DRAW_DONE
  } state_t;

endpackage
`default_nettype wire

/* hdl/mtg_in_if.sv */
`default_nettype none
interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] seed;

  modport source (output valid, output action, output seed, input ready);
  modport sink (input valid, input action, input seed, output ready);
endinterface
`default_nettype wire

/* hdl/mtg_out_if.sv */
`default_nettype none
interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

/* hdl/mtg_cfg_if.sv */
`default_nettype none
interface mtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] default_seed;

  modport source (output valid, output default_seed, input ready);
  modport sink (input valid, input default_seed, output ready);
endinterface
`default_nettype wire

/* hdl/mtg_ram.sv */
`default_nettype none
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* hdl/mtg_alu.sv */
`default_nettype none
module mtg_alu (
  input  wire logic              clk,
  input  wire mtg_pkg::alu_req_t req,
  output      logic [31:0]       res
);

  logic [31:0] res_r;
  logic [31:0] res_nxt;
  logic [31:0] mix;
  logic [31:0] y;
  logic [31:0] t0;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    mix = req.a ^ (req.a >> 30);
    y   = (req.a & mtg_pkg::UPPER_MASK) | (req.b & mtg_pkg::LOWER_MASK);
    t0  = req.a ^ (req.a >> 11);
    t1  = t0 ^ ((t0 << 7) & mtg_pkg::TEMPER_B);
    t2  = t1 ^ ((t1 << 15) & mtg_pkg::TEMPER_C);
    case (req.op)
      mtg_pkg::ALU_ADD:    res_nxt = req.a + req.b;
      mtg_pkg::ALU_MUL:    res_nxt = mix * mtg_pkg::INIT_MULT;
      mtg_pkg::ALU_TWIST:  res_nxt = req.c ^ (y >> 1) ^ (y[0] ? mtg_pkg::MATRIX_A : 32'd0);
      mtg_pkg::ALU_TEMPER: res_nxt = t2 ^ (t2 >> 18);
      default:             res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

/* hdl/mtg_seq.sv */
`default_nettype none
`include "assert_macros.svh"
module mtg_seq #(
  parameter int STATE_WORDS = mtg_pkg::STATE_WORDS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [1:0]                     in_action,
  input  wire logic [31:0]                    in_seed,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [63:0]                    out_value,
  input  wire logic [31:0]                    default_seed,
  output      mtg_pkg::alu_req_t              alu_req,
  input  wire logic [31:0]                    alu_res,
  output      logic                           ram_we,
  output      logic [$clog2(STATE_WORDS)-1:0] ram_waddr,
  output      logic [$clog2(STATE_WORDS)-1:0] ram_raddr,
  input  wire logic [31:0]                    ram_rdata
);

  localparam int AW = $clog2(STATE_WORDS);
  localparam int IW = $clog2(STATE_WORDS + 1);
  localparam logic [AW-1:0] LAST  = AW'(STATE_WORDS - 1);
  localparam logic [IW-1:0] FULL  = IW'(STATE_WORDS);
  localparam logic [AW:0]   OFF_W = (AW+1)'(mtg_pkg::TWIST_OFFSET);
  localparam logic [AW:0]   N_W   = (AW+1)'(STATE_WORDS);

  mtg_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          seeded_r, seeded_nxt;
  logic          draw_r, draw_nxt;
  logic          wide_r, wide_nxt;
  logic          second_r, second_nxt;
  logic [31:0]   seed_r, seed_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   nxt_r, nxt_nxt;
  logic [31:0]   hi_r, hi_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_value_r, out_value_nxt;

  logic [AW-1:0] k_next_addr;
  logic [AW:0]   src_sum;
  logic [AW-1:0] src_addr;
  logic          out_free;

  assign k_next_addr = (k_r == LAST) ? '0 : k_r + AW'(1);
  assign src_sum     = {1'b0, k_r} + OFF_W;
  assign src_addr    = (src_sum >= N_W) ? AW'(src_sum - N_W) : AW'(src_sum);
  assign out_free    = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtg_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            mtg_pkg::ACT_SEED:   state_nxt = mtg_pkg::ST_SEED_INIT;
            mtg_pkg::ACT_DRAW:   state_nxt = mtg_pkg::ST_DRAW_CHK;
            mtg_pkg::ACT_DRAW64: state_nxt = mtg_pkg::ST_DRAW_CHK;
            default:             state_nxt = mtg_pkg::ST_IDLE;
          endcase
        end
      end
      mtg_pkg::ST_SEED_INIT: state_nxt = mtg_pkg::ST_SEED_WR;
      mtg_pkg::ST_SEED_WR: begin
        if (k_r == LAST) begin
          state_nxt = draw_r ? mtg_pkg::ST_DRAW_CHK : mtg_pkg::ST_IDLE;
        end else begin
          state_nxt = mtg_pkg::ST_SEED_MUL;
        end
      end
      mtg_pkg::ST_SEED_MUL: state_nxt = mtg_pkg::ST_SEED_ADD;
      mtg_pkg::ST_SEED_ADD: state_nxt = mtg_pkg::ST_SEED_WR;
      mtg_pkg::ST_DRAW_CHK: begin
        if (!seeded_r) begin
          state_nxt = mtg_pkg::ST_SEED_INIT;
        end else if (idx_r >= FULL) begin
          state_nxt = mtg_pkg::ST_TW_RD0;
        end else begin
          state_nxt = mtg_pkg::ST_DRAW_RD;
        end
      end
      mtg_pkg::ST_TW_RD0:  state_nxt = mtg_pkg::ST_TW_LD;
      mtg_pkg::ST_TW_LD:   state_nxt = mtg_pkg::ST_TW_RDN;
      mtg_pkg::ST_TW_RDN:  state_nxt = mtg_pkg::ST_TW_RDS;
      mtg_pkg::ST_TW_RDS:  state_nxt = mtg_pkg::ST_TW_CALC;
      mtg_pkg::ST_TW_CALC: state_nxt = mtg_pkg::ST_TW_WR;
      mtg_pkg::ST_TW_WR: begin
        state_nxt = (k_r == LAST) ? mtg_pkg::ST_DRAW_CHK : mtg_pkg::ST_TW_RDN;
      end
      mtg_pkg::ST_DRAW_RD:   state_nxt = mtg_pkg::ST_DRAW_TEMP;
      mtg_pkg::ST_DRAW_TEMP: state_nxt = mtg_pkg::ST_DRAW_DONE;
      mtg_pkg::ST_DRAW_DONE: begin
        if (wide_r && !second_r) begin
          state_nxt = mtg_pkg::ST_DRAW_CHK;
        end else if (out_free) begin
          state_nxt = mtg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mtg_pkg::ST_IDLE;
    endcase
  end

  // outputs toward ram and shared unit
  always_comb begin
    in_ready  = (state_r == mtg_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = k_r;
    ram_raddr = '0;
    alu_req   = '{en: 1'b0, op: mtg_pkg::ALU_ADD, a: 32'd0, b: 32'd0, c: 32'd0};
    case (state_r)
      mtg_pkg::ST_SEED_INIT: begin
        alu_req = '{en: 1'b1, op: mtg_pkg::ALU_ADD, a: seed_r, b: 32'd0, c: 32'd0};
      end
      mtg_pkg::ST_SEED_WR: ram_we = 1'b1;
      mtg_pkg::ST_SEED_MUL: begin
        alu_req = '{en: 1'b1, op: mtg_pkg::ALU_MUL, a: alu_res, b: 32'd0, c: 32'd0};
      end
      mtg_pkg::ST_SEED_ADD: begin
        alu_req = '{en: 1'b1, op: mtg_pkg::ALU_ADD, a: alu_res, b: 32'(k_r), c: 32'd0};
      end
      mtg_pkg::ST_TW_RD0: ram_raddr = '0;
      mtg_pkg::ST_TW_RDN: ram_raddr = k_next_addr;
      mtg_pkg::ST_TW_RDS: ram_raddr = src_addr;
      mtg_pkg::ST_TW_CALC: begin
        alu_req = '{en: 1'b1, op: mtg_pkg::ALU_TWIST, a: cur_r, b: nxt_r, c: ram_rdata};
      end
      mtg_pkg::ST_TW_WR: ram_we = 1'b1;
      mtg_pkg::ST_DRAW_RD: ram_raddr = idx_r[AW-1:0];
      mtg_pkg::ST_DRAW_TEMP: begin
        alu_req = '{en: 1'b1, op: mtg_pkg::ALU_TEMPER, a: ram_rdata, b: 32'd0, c: 32'd0};
      end
      default: ram_we = 1'b0;
    endcase
  end

  // counters, flags and data holding registers
  always_comb begin
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    seeded_nxt    = seeded_r;
    draw_nxt      = draw_r;
    wide_nxt      = wide_r;
    second_nxt    = second_r;
    seed_nxt      = seed_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    case (state_r)
      mtg_pkg::ST_IDLE: begin
        if (in_valid) begin
          seed_nxt   = in_seed;
          draw_nxt   = (in_action != mtg_pkg::ACT_SEED);
          wide_nxt   = (in_action == mtg_pkg::ACT_DRAW64);
          second_nxt = 1'b0;
        end
      end
      mtg_pkg::ST_SEED_INIT: k_nxt = '0;
      mtg_pkg::ST_SEED_WR: begin
        if (k_r == LAST) begin
          idx_nxt    = FULL;
          seeded_nxt = 1'b1;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      mtg_pkg::ST_DRAW_CHK: begin
        if (!seeded_r) begin
          seed_nxt = default_seed;
        end
      end
      mtg_pkg::ST_TW_RD0: k_nxt = '0;
      mtg_pkg::ST_TW_LD: cur_nxt = ram_rdata;
      mtg_pkg::ST_TW_RDS: nxt_nxt = ram_rdata;
      mtg_pkg::ST_TW_WR: begin
        cur_nxt = nxt_r;
        if (k_r == LAST) begin
          idx_nxt = '0;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      mtg_pkg::ST_DRAW_RD: idx_nxt = idx_r + IW'(1);
      mtg_pkg::ST_DRAW_DONE: begin
        if (wide_r && !second_r) begin
          hi_nxt     = alu_res;
          second_nxt = 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = wide_r ? {hi_r, alu_res} : {32'd0, alu_res};
        end
      end
      default: k_nxt = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtg_pkg::ST_IDLE;
      k_r         <= '0;
      idx_r       <= '0;
      seeded_r    <= 1'b0;
      draw_r      <= 1'b0;
      wide_r      <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      idx_r       <= idx_nxt;
      seeded_r    <= seeded_nxt;
      draw_r      <= draw_nxt;
      wide_r      <= wide_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_r      <= seed_nxt;
    cur_r       <= cur_nxt;
    nxt_r       <= nxt_nxt;
    hi_r        <= hi_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  `MTG_ASSERT(a_idx_range, clk, rst_n, idx_r <= FULL, "read index past end of table")
  `MTG_ASSERT(a_we_states, clk, rst_n, ram_we |-> (state_r == mtg_pkg::ST_SEED_WR || state_r == mtg_pkg::ST_TW_WR), "table write outside a write state")
  `MTG_ASSERT(a_twist_wrap, clk, rst_n, (state_r == mtg_pkg::ST_TW_WR && k_r == LAST) |=> (idx_r == '0 && state_r == mtg_pkg::ST_DRAW_CHK), "twist end did not rewind index")
  `MTG_ASSERT(a_draw_ok, clk, rst_n, (state_r == mtg_pkg::ST_DRAW_RD) |-> (seeded_r && idx_r < FULL), "table read while unseeded or exhausted")
  `MTG_ASSERT(a_out_hold, clk, rst_n, (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_value_r)), "pending result lost")

endmodule
`default_nettype wire

/* hdl/mersenne_twister_generator_top.sv */
`default_nettype none
// mt19937 generator: one word in flight at a time, ready only while idle. a seed word
// fills the 624-entry state table with the standard init recurrence through one shared
// multiply/add unit, writing, multiplying and adding for each entry in turn, and gives no
// result. a draw gives one tempered word in value[31:0] (upper half zero); a draw64 gives
// two, first word in value[63:32]. whenever the table is used up a regeneration pass runs
// first (once every 624 words), its reads per entry taken in turn through the single read
// port of the table ram. a draw before any seed first seeds from the default_seed register
// (reset 5489), written over the cfg channel; the user must write it only while idle, the
// block does not enforce this. action code 3 is accepted and dropped. the table has no
// reset and no clearing pass; it is always written before it is read. a finished result
// sits in an output register, so the next word can be taken while it waits.
module mersenne_twister_generator_top #(
  parameter int STATE_WORDS = mtg_pkg::STATE_WORDS
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mtg_in_if.sink     in_chan,
  mtg_out_if.source  out_chan,
  mtg_cfg_if.sink    cfg_chan
);

  localparam int AW = $clog2(STATE_WORDS);

  logic [31:0]       default_seed_r;
  mtg_pkg::alu_req_t alu_req;
  logic [31:0]       alu_res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;

  // config register, always writable; the user must write it only while idle, the block does not enforce this
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_seed_r <= mtg_pkg::DEFAULT_SEED_RST;
    end else if (cfg_chan.valid) begin
      default_seed_r <= cfg_chan.default_seed;
    end
  end

  // sequencer: seeding, regeneration pass and draws
  mtg_seq #(
    .STATE_WORDS (STATE_WORDS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_action    (in_chan.action),
    .in_seed      (in_chan.seed),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_value    (out_chan.value),
    .default_seed (default_seed_r),
    .alu_req      (alu_req),
    .alu_res      (alu_res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  // shared unit: init multiply, add, twist step, tempering
  mtg_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .res (alu_res)
  );

  // state table, write data always comes from the shared unit result
  mtg_ram #(
    .WIDTH (mtg_pkg::WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (alu_res),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mtg_pkg::*;

  // action code 3 is accepted by the block and dropped
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int ITEM_TARGET   = 1600;
  // longest work without a result: the seed fill
  localparam int SETTLE_CYCLES = 2500;
  // long receiver hold-offs, so the block fills up and stalls its input
  localparam int HOLD_CYCLES   = 600;
  localparam int HOLD_AT_A     = 50;
  localparam int HOLD_AT_B     = 700;
  localparam int MAX_REPORTS   = 20;

  logic clk;
  logic rst_n;

  mtg_in_if  in_if ();
  mtg_out_if out_if ();
  mtg_cfg_if cfg_if ();

  mersenne_twister_generator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // mt19937 sequence predictor and store of the draws still owed by the block
  class mt_scoreboard;
    bit [31:0] tbl [STATE_WORDS];
    int unsigned rd_idx;
    bit seeded;
    bit [31:0] fallback_seed;
    bit [63:0] owed_values [$];
    int unsigned errors;

    function new();
      rd_idx = 0;
      seeded = 1'b0;
      fallback_seed = DEFAULT_SEED_RST;
      errors = 0;
    endfunction

    function void set_fallback(bit [31:0] v);
      fallback_seed = v;
    endfunction

    function void fill_table(bit [31:0] s);
      bit [31:0] p;
      tbl[0] = s;
      for (int i = 1; i < STATE_WORDS; i++) begin
        p = tbl[i - 1];
        tbl[i] = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
      end
      rd_idx = STATE_WORDS;
      seeded = 1'b1;
    endfunction

    // in-place regeneration of the whole table
    function void regenerate_table();
      bit [31:0] y;
      bit [31:0] v;
      for (int k = 0; k < STATE_WORDS; k++) begin
        y = (tbl[k] & UPPER_MASK) | (tbl[(k + 1) % STATE_WORDS] & LOWER_MASK);
        v = tbl[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
        if (y[0]) v ^= MATRIX_A;
        tbl[k] = v;
      end
      rd_idx = 0;
    endfunction

    function bit [31:0] next_tempered();
      bit [31:0] y;
      if (!seeded) fill_table(fallback_seed);
      if (rd_idx >= STATE_WORDS) regenerate_table();
      y = tbl[rd_idx];
      rd_idx++;
      y ^= y >> 11;
      y ^= (y << 7) & TEMPER_B;
      y ^= (y << 15) & TEMPER_C;
      y ^= y >> 18;
      return y;
    endfunction

    function void note_word(logic [1:0] act, logic [31:0] sd);
      bit [31:0] hi;
      bit [31:0] lo;
      case (act)
        ACT_SEED: begin
          fill_table(sd);
        end
        ACT_DRAW: begin
          owed_values.push_back({32'h0, next_tempered()});
        end
        ACT_DRAW64: begin
          hi = next_tempered();
          lo = next_tempered();
          owed_values.push_back({hi, lo});
        end
        default: begin
        end
      endcase
    endfunction

    function void check_word(logic [63:0] value);
      bit [63:0] want;
      if (owed_values.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, value);
        errors++;
      end else begin
        want = owed_values.pop_front();
        if (value !== want) begin
          if (errors < MAX_REPORTS)
            $display("%0t: value mismatch, expected %h, actual %h", $time, want, value);
          errors++;
        end
      end
    endfunction
  endclass

  mt_scoreboard sb = new();

  int unsigned words_sent = 0;
  int src_calm = 0;
  int snk_calm = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #15ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // gap before a word: mostly random, with calm stretches of no idling
  function automatic int draw_gap(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // monitors sample the handshakes at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_word(in_if.action, in_if.seed);
      if (out_if.valid && out_if.ready) sb.check_word(out_if.value);
    end
  end

  // result receiver, with its own stalls and two long hold-offs
  initial begin
    int stall;
    int taken;
    taken = 0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_gap(snk_calm);
      if (taken == HOLD_AT_A || taken == HOLD_AT_B) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      taken++;
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [31:0] sd);
    int gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.seed   <= sd;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (act != ACT_UNUSED) words_sent++;
  endtask

  // drop valid, let every owed result arrive, then cover a seed fill still running
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.owed_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed_reg(input logic [31:0] v);
    cfg_if.valid        <= 1'b1;
    cfg_if.default_seed <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    sb.set_fallback(v);
  endtask

  initial begin
    int len;
    int cfg_step;
    int cfg_mark;
    logic [31:0] sd;
    cfg_step = 0;
    cfg_mark = 500;

    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.action        <= ACT_SEED;
    in_if.seed          <= 32'h0;
    cfg_if.valid        <= 1'b0;
    cfg_if.default_seed <= 32'h0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // the default seed only matters for the first draw after reset
    write_seed_reg(32'hffffffff);

    // directed: dropped code before any seed, then a 64-bit draw that self-seeds
    send_word(ACT_UNUSED, 32'h12345678);
    send_word(ACT_DRAW64, 32'hdeadbeef);
    send_word(ACT_DRAW, 32'h0);
    // field extremes of the seed
    send_word(ACT_SEED, 32'h0);
    send_word(ACT_DRAW, 32'hffffffff);
    send_word(ACT_DRAW64, 32'h0);
    send_word(ACT_SEED, 32'hffffffff);
    send_word(ACT_DRAW64, 32'hffffffff);
    send_word(ACT_DRAW, 32'h55555555);
    // dropped code mid-sequence leaves the state alone
    send_word(ACT_UNUSED, 32'hffffffff);
    send_word(ACT_DRAW, 32'haaaaaaaa);
    send_word(ACT_SEED, 32'd5489);
    send_word(ACT_DRAW, 32'h0);
    send_word(ACT_SEED, 32'h80000000);
    send_word(ACT_DRAW64, 32'h7fffffff);
    // reseeding restarts the sequence
    send_word(ACT_SEED, 32'h1);
    send_word(ACT_DRAW, 32'h0);
    send_word(ACT_SEED, 32'h1);
    send_word(ACT_DRAW, 32'h0);
    send_word(ACT_DRAW64, 32'h0);
    wait_idle();
    write_seed_reg(32'h0);

    // random: runs of draws, most behind a fresh seed, some long enough to wrap
    while (words_sent < ITEM_TARGET) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(330, 700) : $urandom_range(1, 40);
      if ($urandom_range(0, 99) < 85) begin
        sd = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'hffffffff : 32'h0)
                                         : $urandom();
        send_word(ACT_SEED, sd);
      end
      repeat (len) begin
        if ($urandom_range(0, 24) == 0) send_word(ACT_UNUSED, $urandom());
        if ($urandom_range(0, 59) == 0) send_word(ACT_SEED, $urandom());
        send_word($urandom_range(0, 1) ? ACT_DRAW64 : ACT_DRAW, $urandom());
      end
      if (words_sent >= cfg_mark && cfg_step < 2) begin
        wait_idle();
        write_seed_reg(cfg_step == 0 ? $urandom() : 32'hffffffff);
        cfg_step++;
        cfg_mark += 500;
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.owed_values.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
